// File: design/i2cbt_pkg.sv
package i2cbt_pkg;

	// operand width of the shared divider
	localparam int unsigned DATA_W = 32;

	// noise filter stages assumed in the bus timing
	localparam int unsigned FILTER_STAGES = 4;

	// per-side overhead in divided clocks: shift 0, other shifts
	localparam int unsigned OVH_SHIFT0 = 3 + FILTER_STAGES;
	localparam int unsigned OVH_OTHER  = 2 + FILTER_STAGES;

	// legal range of low plus high count
	localparam int unsigned MIN_SUM = 2 * (FILTER_STAGES + 1);
	localparam int unsigned MAX_SUM = 62;

	// clocks per bit never exceed this once the range check passes
	localparam int unsigned PB_W = 7;
	localparam int unsigned SUM_W = 6;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned SHIFT_W = 3;

	localparam logic [SHIFT_W-1:0] LAST_SHIFT = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV1,
		ST_DIV2,
		ST_CMP
	} state_t;

endpackage

// File: design/i2c_bit_timing_search.sv
// Sequence, from the accepting edge to the result beat: a zero wanted rate fails at
// once; otherwise each shift tried is dropped when the divided clock is below the rate,
// after the first division when that is out of range, or after both divisions run.
// Throughput: one item at a time; busy drops in the cycle of the result beat.
// Reset: arst_n clears the sequencer and the done strobe; no clearing pass.
// The result beat lasts one cycle; the receiver cannot stall it.
module i2c_bit_timing_search
	import i2cbt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [DATA_W-1:0]   clock_hz,
	input  logic [DATA_W-1:0]   wanted_rate_hz,
	output logic                done,
	output logic                status,
	output logic [SHIFT_W-1:0]  prescale_shift,
	output logic [CNT_W-1:0]    low_count,
	output logic [CNT_W-1:0]    high_count
);

	localparam int unsigned ERR_W = DATA_W + 4;   // room for err * 10

	state_t state_q, state_d;

	// item operands and per-shift working values
	logic [DATA_W-1:0]  clk_q;
	logic [DATA_W-1:0]  rate_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [DATA_W-1:0]  div_clk_q;
	logic [PB_W-1:0]    per_bit_q;
	logic [DATA_W-1:0]  err_q;

	// result beat
	logic               done_q;
	logic               status_q;
	logic [SHIFT_W-1:0] shift_out_q;
	logic [CNT_W-1:0]   low_q;
	logic [CNT_W-1:0]   high_q;

	// shared divider hookup
	logic               div_start;
	logic [DATA_W-1:0]  div_a;
	logic [DATA_W-1:0]  div_b;
	logic               div_done;
	logic [DATA_W-1:0]  quo;

	// sequencer decisions
	logic               accept;
	logic               skip;
	logic               last;
	logic               found;
	logic               fail;

	// datapath helpers
	logic [DATA_W-1:0]  shifted;
	logic [DATA_W-1:0]  twice_ovh;
	logic [DATA_W-1:0]  pb_lo;
	logic [DATA_W-1:0]  pb_hi;
	logic [DATA_W-1:0]  err_d;
	logic [ERR_W-1:0]   err10;
	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   twice_ovh_n;
	logic [CNT_W-1:0]   lo_cnt;
	logic [SUM_W-1:0]   hi_full;

	i2cbt_div #(
		.W(DATA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	// divided clock for the shift under test
	assign shifted = clk_q >> shift_q;

	// overhead is larger without the prescaler
	assign twice_ovh   = (shift_q == '0) ? DATA_W'(2 * OVH_SHIFT0) : DATA_W'(2 * OVH_OTHER);
	assign twice_ovh_n = twice_ovh[SUM_W-1:0];

	// clocks per bit must leave a sum inside MIN_SUM..MAX_SUM
	assign pb_lo = twice_ovh + DATA_W'(MIN_SUM);
	assign pb_hi = twice_ovh + DATA_W'(MAX_SUM);

	// |achieved - wanted|, taken when the second division ends
	assign err_d = (quo > rate_q) ? (quo - rate_q) : (rate_q - quo);

	// err * 10 as err * 8 + err * 2
	assign err10 = {1'b0, err_q, 3'b000} + {3'b000, err_q, 1'b0};

	// split of the sum: low gets the lower half
	assign sum     = SUM_W'(per_bit_q) - twice_ovh_n;
	assign lo_cnt  = sum[SUM_W-1:1];
	assign hi_full = sum - {1'b0, lo_cnt};

	assign last = (shift_q == LAST_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		skip      = 1'b0;
		found     = 1'b0;
		div_start = 1'b0;
		div_a     = div_clk_q;
		div_b     = rate_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					accept = 1'b1;
					if (wanted_rate_hz != '0)
						state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				// divided clock slower than the bus: shift cannot work
				if (shifted < rate_q) begin
					skip = 1'b1;
				end else begin
					div_start = 1'b1;
					div_a     = shifted;
					state_d   = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (div_done) begin
					if (quo inside {[pb_lo:pb_hi]}) begin
						// achieved rate = divided clock / clocks per bit
						div_start = 1'b1;
						div_b     = {{(DATA_W-PB_W){1'b0}}, quo[PB_W-1:0]};
						state_d   = ST_DIV2;
					end else begin
						skip = 1'b1;
					end
				end
			end
			ST_DIV2: begin
				if (div_done)
					state_d = ST_CMP;
			end
			ST_CMP: begin
				// within a tenth of the wanted rate
				if (err10 > {4'b0000, rate_q}) begin
					skip = 1'b1;
				end else begin
					found   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (skip)
			state_d = last ? ST_IDLE : ST_PREP;
	end

	// zero rate fails at once; otherwise fail after the last shift is dropped
	assign fail = (accept && (wanted_rate_hz == '0)) || (skip && last);

	always_ff @(posedge clk) begin
		if (accept) begin
			clk_q   <= clock_hz;
			rate_q  <= wanted_rate_hz;
			shift_q <= '0;
		end else if (skip && !last) begin
			shift_q <= shift_q + 1'b1;
		end
		if (state_q == ST_PREP)
			div_clk_q <= shifted;
		if ((state_q == ST_DIV1) && div_done)
			per_bit_q <= quo[PB_W-1:0];
		if ((state_q == ST_DIV2) && div_done)
			err_q <= err_d;
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= found || fail;
	end

	always_ff @(posedge clk) begin
		if (found) begin
			status_q    <= 1'b0;
			shift_out_q <= shift_q;
			low_q       <= lo_cnt;
			high_q      <= hi_full[CNT_W-1:0];
		end else if (fail) begin
			status_q    <= 1'b1;
			shift_out_q <= '0;
			low_q       <= '0;
			high_q      <= '0;
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign prescale_shift = shift_out_q;
	assign low_count      = low_q;
	assign high_count     = high_q;

endmodule

// File: design/i2cbt_div.sv
module i2cbt_div
	import i2cbt_pkg::*;
#(
	parameter int unsigned W = DATA_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dq_q;    // dividend bits shift out, quotient bits shift in
	logic [W-1:0]  dvs_q;

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	// one restoring step per cycle
	assign trial = {rem_q, dq_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == LAST);
			if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			dq_q  <= {dq_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule
